FILE: design/asav_pkg.sv
// ----------------------------------------------------------------------------
// asav_pkg
// Shared widths, ASCII codes, character positions and the digit split helper
// for the ADC sample to ASCII volts readout.
// ----------------------------------------------------------------------------
package asav_pkg;

    localparam int RAW_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int NIB_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int GAIN_W     = 10;
    localparam int COUNT_W    = 19;
    localparam int PROD_W     = COUNT_W + GAIN_W;
    localparam int NUM_DIGITS = 5;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd952;

    // Word index taken from paddr[2]
    localparam logic REG_GAIN = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_VOLT  = 8'h56;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Weight of each shown digit, in units of 1e-8 V, most significant first
    localparam logic [PROD_W-1:0] DIGIT_UNIT [NUM_DIGITS] = '{
        29'd100000000, 29'd10000000, 29'd1000000, 29'd100000, 29'd10000
    };

    typedef logic [3:0] t_digit;

    typedef enum logic [3:0] {
        POS_CHAN,
        POS_UNITS,
        POS_DOT,
        POS_TENTHS,
        POS_HUNDREDTHS,
        POS_THOUSANDTHS,
        POS_TEN_THOUSANDTHS,
        POS_VOLT,
        POS_SPACE
    } t_pos;

    typedef struct packed {
        logic [NIB_W-1:0]              chan;
        t_digit [NUM_DIGITS-1:0]       digits;  // [0] is the units digit
    } t_readout;

    typedef struct packed {
        t_digit            digit;
        logic [PROD_W-1:0] rem;
    } t_split;

    // value must be below ten times unit
    function automatic t_split digit_split(input logic [PROD_W-1:0] value,
                                           input logic [PROD_W-1:0] unit);
        t_split            s;
        logic [PROD_W+3:0] mult;
        s.digit = '0;
        s.rem   = value;
        for (int k = 1; k < 10; k++) begin
            mult = (PROD_W+4)'(k) * {4'b0, unit};
            if ({4'b0, value} >= mult) begin
                s.digit = t_digit'(k);
                s.rem   = value - mult[PROD_W-1:0];
            end
        end
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [NIB_W-1:0] nib);
        return CHAR_ZERO + {{(CHAR_W-NIB_W){1'b0}}, nib};
    endfunction

endpackage

FILE: design/asav_ifs.sv
// ----------------------------------------------------------------------------
// asav_ifs
// Valid/ready channels: sample input and readout character output.
// ----------------------------------------------------------------------------
interface asav_in_if import asav_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RAW_W-1:0]  raw_sample;
    logic [CHAN_W-1:0] channel_code;

    modport source (output valid, output raw_sample, output channel_code, input ready);
    modport sink   (input valid, input raw_sample, input channel_code, output ready);
endinterface

interface asav_out_if import asav_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

FILE: design/asav_cfg.sv
// ----------------------------------------------------------------------------
// asav_cfg
// APB register file holding the volts gain.
// ----------------------------------------------------------------------------
module asav_cfg import asav_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [GAIN_W-1:0] o_gain
);

    logic [GAIN_W-1:0] r_gain;
    logic              w_sel_gain;

    assign pready     = 1'b1;
    assign w_sel_gain = (paddr[2] == REG_GAIN);
    assign prdata     = w_sel_gain ? {{(APB_DW-GAIN_W){1'b0}}, r_gain} : '0;
    assign o_gain     = r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_gain) begin
            r_gain <= pwdata[GAIN_W-1:0];
        end
    end

endmodule

FILE: design/asav_conv.sv
// ----------------------------------------------------------------------------
// asav_conv
// Sample capture, gain multiply and one decimal digit per stage.
// ----------------------------------------------------------------------------
module asav_conv import asav_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [GAIN_W-1:0] i_gain,
    asav_in_if.sink           i_in,
    output logic              o_valid,
    input  logic              i_ready,
    output t_readout          o_item
);

    localparam int NSTG = NUM_DIGITS + 2;

    logic                      r_vld  [NSTG];
    logic [NIB_W-1:0]          r_chan [NSTG];
    logic                      w_load [NSTG+1];

    logic                      r_neg;
    logic [COUNT_W-1:0]        r_count;
    logic [PROD_W-1:0]         r_prod;
    logic [PROD_W-1:0]         r_rem  [NUM_DIGITS-1];
    t_digit [NUM_DIGITS-1:0]   r_dig  [NUM_DIGITS];

    // ready ripples back through empty or moving stages
    always_comb begin
        w_load[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
    end

    assign i_in.ready = w_load[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (w_load[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_neg     <= i_in.raw_sample[RAW_W-1];
            r_count   <= i_in.raw_sample[RAW_W-2:RAW_W-1-COUNT_W];
            r_chan[0] <= i_in.channel_code[CHAN_W-1:CHAN_W-NIB_W];
        end
        if (w_load[1]) begin
            r_prod    <= r_neg ? '0 : PROD_W'(r_count) * PROD_W'(i_gain);
            r_chan[1] <= r_chan[0];
        end
    end

    for (genvar j = 0; j < NUM_DIGITS; j++) begin : g_digit
        logic [PROD_W-1:0]       w_src;
        t_digit [NUM_DIGITS-1:0] w_prev;
        t_digit [NUM_DIGITS-1:0] w_next;
        t_split                  w_split;

        if (j == 0) begin : g_first
            assign w_src  = r_prod;
            assign w_prev = '0;
        end else begin : g_next
            assign w_src  = r_rem[j-1];
            assign w_prev = r_dig[j-1];
        end

        assign w_split = digit_split(w_src, DIGIT_UNIT[j]);

        always_comb begin
            w_next    = w_prev;
            w_next[j] = w_split.digit;
        end

        always_ff @(posedge i_clk) begin
            if (w_load[j+2]) begin
                r_chan[j+2] <= r_chan[j+1];
                r_dig[j]    <= w_next;
            end
        end

        if (j < NUM_DIGITS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (w_load[j+2]) begin
                    r_rem[j] <= w_split.rem;
                end
            end
        end
    end

    assign o_valid       = r_vld[NSTG-1];
    assign o_item.chan   = r_chan[NSTG-1];
    assign o_item.digits = r_dig[NUM_DIGITS-1];

endmodule

FILE: design/asav_ser.sv
// ----------------------------------------------------------------------------
// asav_ser
// Holds one readout and sends its nine characters, one per beat.
// ----------------------------------------------------------------------------
module asav_ser import asav_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_readout i_item,
    asav_out_if.source o_out
);

    logic     r_full;
    t_pos     r_idx;
    t_readout r_item;
    logic     w_fire;
    logic     w_done;

    assign w_fire  = r_full && o_out.ready;
    assign w_done  = w_fire && (r_idx == POS_SPACE);
    assign o_ready = !r_full || w_done;

    assign o_out.valid     = r_full;
    assign o_out.last_char = (r_idx == POS_SPACE);

    always_comb begin
        case (r_idx)
            POS_CHAN:            o_out.text_char = to_ascii(r_item.chan);
            POS_UNITS:           o_out.text_char = to_ascii(r_item.digits[0]);
            POS_DOT:             o_out.text_char = CHAR_DOT;
            POS_TENTHS:          o_out.text_char = to_ascii(r_item.digits[1]);
            POS_HUNDREDTHS:      o_out.text_char = to_ascii(r_item.digits[2]);
            POS_THOUSANDTHS:     o_out.text_char = to_ascii(r_item.digits[3]);
            POS_TEN_THOUSANDTHS: o_out.text_char = to_ascii(r_item.digits[4]);
            POS_VOLT:            o_out.text_char = CHAR_VOLT;
            default:             o_out.text_char = CHAR_SPACE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= POS_CHAN;
        end else if (i_valid && o_ready) begin
            r_full <= 1'b1;
            r_idx  <= POS_CHAN;
        end else if (w_done) begin
            r_full <= 1'b0;
            r_idx  <= POS_CHAN;
        end else if (w_fire) begin
            r_idx  <= t_pos'(r_idx + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    a_take_starts_at_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_full && r_idx == POS_CHAN)
        else $error("new readout does not start at the channel character");

    a_mid_beat_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !o_out.last_char |=> r_full && r_idx == t_pos'($past(r_idx) + 4'd1))
        else $error("readout broken off or position skipped");

    a_last_is_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full && o_out.last_char |-> o_out.text_char == CHAR_SPACE)
        else $error("last beat is not the trailing space");

endmodule

FILE: design/adc_sample_to_ascii_volts.sv
// ----------------------------------------------------------------------------
// adc_sample_to_ascii_volts
// Converts a 24-bit ADC code and channel byte into a nine character
// readout "C" "D.DDDDV" " " with the gain set over APB.
// ----------------------------------------------------------------------------
// Path: a taken sample passes the capture, multiply and digit stages and the
// serializer register. Throughput: one character per cycle while o_text.ready
// is high, set by the serializer; the seven stage pipeline buffers behind it.
// Reset: synchronous, active low; pipeline empty, gain back to 952.
module adc_sample_to_ascii_volts import asav_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    asav_in_if.sink           i_sample,
    asav_out_if.source        o_text,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [GAIN_W-1:0] w_gain;
    logic              w_valid;
    logic              w_ready;
    t_readout          w_item;

    asav_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gain  (w_gain)
    );

    asav_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (w_gain),
        .i_in    (i_sample),
        .o_valid (w_valid),
        .i_ready (w_ready),
        .o_item  (w_item)
    );

    asav_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .o_ready (w_ready),
        .i_item  (w_item),
        .o_out   (o_text)
    );

endmodule
